// ===== rtl/mesh_corner_vertex_dedup_macros.svh =====
// Assertion macros used by the top level of the vertex dedup RTL.
`ifndef MESH_CORNER_VERTEX_DEDUP_MACROS_SVH
`define MESH_CORNER_VERTEX_DEDUP_MACROS_SVH

`ifndef SYNTH
// Implication or plain property, sampled on the rising clock, off during reset.
`define MCVD_ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("mcvd assertion failed");
// Condition that must never be true.
`define MCVD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("mcvd forbidden condition seen");
`else
`define MCVD_ASSERT_CLK(label, clk, rst_n, prop)
`define MCVD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/mcvd_pkg.sv =====
// Types and constants shared by the vertex dedup modules.
package mcvd_pkg;

	// Table size and derived widths
	localparam int MAX_VERTICES = 256;
	localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// Field widths
	localparam int POS_W  = 16;
	localparam int TEX_W  = 16;
	localparam int KEY_W  = POS_W + TEX_W;
	localparam int NUM_W  = 8;
	localparam int DCNT_W = 9;

	// Request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic             first;
		logic [KEY_W-1:0] key;
	} corner_req_t;

	typedef struct packed {
		logic        vld;
		corner_req_t req;
	} queue_head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FINISH
	} back_state_t;

endpackage

// ===== rtl/mcvd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mcvd_front.sv =====
// Front end: takes corner requests, forms the pair key, queues them.
module mcvd_front import mcvd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             first_of_mesh,
	input  logic [POS_W-1:0] position_index,
	input  logic [TEX_W-1:0] texcoord_index,
	output queue_head_t      head,
	input  logic             pop
);

	corner_req_t       fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              do_pop;
	corner_req_t       new_req;

	// Classify: the pair becomes one compare key
	always_comb begin
		new_req.first = first_of_mesh;
		new_req.key   = {position_index, texcoord_index};
	end

	assign in_stall = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (cnt_q != '0);

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_req;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head.vld = (cnt_q != '0);
	assign head.req = fifo_q[rd_ptr_q];

endmodule

// ===== rtl/mcvd_back.sv =====
// Back end: scans the pair table, appends new pairs, holds the result.
module mcvd_back import mcvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  queue_head_t       head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NUM_W-1:0]  vertex_number,
	output logic              is_new_vertex,
	output logic              table_overflow,
	output logic [DCNT_W-1:0] distinct_count
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  pend_idx_s1;
	logic [IDX_W-1:0]  num_q;
	logic              new_q;
	logic              ovf_q;
	logic              out_vld_q;
	logic [NUM_W-1:0]  out_num_q;
	logic              out_new_q;
	logic              out_ovf_q;
	logic [DCNT_W-1:0] out_cnt_q;
	logic              issue;
	logic              hit;
	logic              miss;
	logic              room;
	logic              load_out;
	logic              we;
	logic [KEY_W-1:0]  rdata;

	// Pair table
	mcvd_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_VERTICES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (key_q),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Control outputs of the sequencer
	always_comb begin
		room     = (count_q < CNT_W'(MAX_VERTICES));
		pop      = (state_q == BK_IDLE) && head.vld;
		issue    = (state_q == BK_SCAN) && (idx_q < count_q);
		hit      = (state_q == BK_SCAN) && pend_s1 && (rdata == key_q);
		miss     = (state_q == BK_SCAN) && !pend_s1 && !issue;
		we       = miss && room;
		load_out = (state_q == BK_FINISH) && (!out_vld_q || !out_stall);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE:   if (pop) state_d = BK_SCAN;
			BK_SCAN:   if (hit || miss) state_d = BK_FINISH;
			BK_FINISH: if (load_out) state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= issue;
			if (pop) begin
				idx_q <= '0;
				if (head.req.first) begin
					count_q <= '0;
				end
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		pend_idx_s1 <= idx_q[IDX_W-1:0];
		if (pop) begin
			key_q <= head.req.key;
		end
		if (hit) begin
			num_q <= pend_idx_s1;
			new_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (miss) begin
			new_q <= 1'b1;
			ovf_q <= !room;
			num_q <= room ? count_q[IDX_W-1:0] : '0;
		end
		if (load_out) begin
			out_num_q <= NUM_W'(num_q);
			out_new_q <= new_q;
			out_ovf_q <= ovf_q;
			out_cnt_q <= DCNT_W'(count_q);
		end
	end

	assign out_valid      = out_vld_q;
	assign vertex_number  = out_num_q;
	assign is_new_vertex  = out_new_q;
	assign table_overflow = out_ovf_q;
	assign distinct_count = out_cnt_q;

endmodule

// ===== rtl/mesh_corner_vertex_dedup.sv =====
// Top level of the corner-to-vertex deduplicator.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------------
//   in       | in_valid / in_stall | first_of_mesh, position_index, texcoord_index
//   out      | out_valid/out_stall | vertex_number, is_new_vertex, table_overflow,
//            |                     | distinct_count
//
// A new pair runs through the back end in order: pop the queue, one table read per stored
// pair through the single RAM read port, the read latency for the last compare, the append
// and the result load; on an empty table the reads and the last compare are skipped. A hit
// on entry k ends the scan there, without the append. A held result keeps the back end
// waiting; the two-entry request queue keeps accepting until it is full. Reset empties
// the queue and the table count; no clearing pass.
module mesh_corner_vertex_dedup import mcvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              first_of_mesh,
	input  logic [POS_W-1:0]  position_index,
	input  logic [TEX_W-1:0]  texcoord_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NUM_W-1:0]  vertex_number,
	output logic              is_new_vertex,
	output logic              table_overflow,
	output logic [DCNT_W-1:0] distinct_count
);

`include "mesh_corner_vertex_dedup_macros.svh"

	queue_head_t head;
	logic        pop;

	// Front: accept and queue requests
	mcvd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_of_mesh  (first_of_mesh),
		.position_index (position_index),
		.texcoord_index (texcoord_index),
		.head           (head),
		.pop            (pop)
	);

	// Back: table search and result
	mcvd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.vertex_number  (vertex_number),
		.is_new_vertex  (is_new_vertex),
		.table_overflow (table_overflow),
		.distinct_count (distinct_count)
	);

	// Back end only takes a request that is there
	`MCVD_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !head.vld)
	// Overflow is a new pair reported as vertex zero
	`MCVD_ASSERT_CLK(a_ovf_form, clk, arst_n, (out_valid && table_overflow) |-> (is_new_vertex && (vertex_number == '0)))
	// A stored new pair gets the number just below the new count
	`MCVD_ASSERT_CLK(a_new_num, clk, arst_n, (out_valid && is_new_vertex && !table_overflow) |-> (vertex_number == NUM_W'(distinct_count - DCNT_W'(1))))

endmodule

// ===== bench/mesh_corner_vertex_dedup_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the corner-to-vertex deduplicator: directed corners, random meshes.
module mesh_corner_vertex_dedup_tb;
	import mcvd_pkg::*;

	// A corner costs at most a full table scan in the block, plus the largest sender gap and
	// receiver stall; the long hold-off is HOLDOFF_LEN. The quiet limit is several times that.
	localparam int QUIET_LIMIT  = 5000;
	localparam int HOLDOFF_LEN  = 500;
	localparam int TAIL_CYCLES  = 400;
	localparam int TOTAL_ITEMS  = 966;
	localparam int REPORT_CAP   = 40;
	localparam int FULL_MESH_LEN = 300;

	typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

	typedef struct {
		logic             first;
		logic [POS_W-1:0] pos;
		logic [TEX_W-1:0] tex;
		bit               drain;
	} corner_item_t;

	typedef struct packed {
		logic [NUM_W-1:0]  number;
		logic              is_new;
		logic              overflow;
		logic [DCNT_W-1:0] count;
	} vertex_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              first_of_mesh = 1'b0;
	logic [POS_W-1:0]  position_index = '0;
	logic [TEX_W-1:0]  texcoord_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [NUM_W-1:0]  vertex_number;
	logic              is_new_vertex;
	logic              table_overflow;
	logic [DCNT_W-1:0] distinct_count;

	// Bench state
	corner_item_t      pending_corners[$];
	vertex_result_t    expected_vertices[$];
	logic [KEY_W-1:0]  known_pairs[MAX_VERTICES];
	int unsigned       known_count = 0;
	int                mismatch_count = 0;
	int                results_seen = 0;
	int                quiet_cycles = 0;
	logic              in_took = 1'b0;
	logic              out_took = 1'b0;
	logic              drv_busy = 1'b0;
	int                in_gap = 0;
	int                out_wait = 0;
	int                holdoff_left = 0;
	idle_mode_t        in_mode = IDLE_FULL;
	idle_mode_t        out_mode = IDLE_FULL;

	mesh_corner_vertex_dedup u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_of_mesh  (first_of_mesh),
		.position_index (position_index),
		.texcoord_index (texcoord_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.vertex_number  (vertex_number),
		.is_new_vertex  (is_new_vertex),
		.table_overflow (table_overflow),
		.distinct_count (distinct_count)
	);

	always #5 clk = ~clk;

	// Dedup prediction: linear search of the pairs stored in this mesh
	function automatic vertex_result_t predict_corner(input logic first,
			input logic [POS_W-1:0] pos, input logic [TEX_W-1:0] tex);
		vertex_result_t   r;
		logic [KEY_W-1:0] key;
		int               hit;
		key = {pos, tex};
		if (first)
			known_count = 0;
		hit = -1;
		for (int k = 0; k < known_count; k++)
			if (hit < 0 && known_pairs[k] == key)
				hit = k;
		r.is_new = (hit < 0);
		r.overflow = 1'b0;
		if (hit >= 0) begin
			r.number = hit[NUM_W-1:0];
		end else if (known_count < MAX_VERTICES) begin
			known_pairs[known_count] = key;
			r.number = known_count[NUM_W-1:0];
			known_count++;
		end else begin
			// table full: new pair is dropped
			r.overflow = 1'b1;
			r.number = '0;
		end
		r.count = known_count[DCNT_W-1:0];
		return r;
	endfunction

	function automatic int draw_wait(inout idle_mode_t mode);
		if ($urandom_range(0, 39) == 0)
			mode = idle_mode_t'($urandom_range(0, 2));
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return $urandom_range(0, 3);
			default:    return $urandom_range(0, 17);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < REPORT_CAP)
			$display("%0t ns: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic add_corner(input logic first, input logic [KEY_W-1:0] key, input bit drain);
		corner_item_t c;
		c.first = first;
		c.pos = key[KEY_W-1:TEX_W];
		c.tex = key[TEX_W-1:0];
		c.drain = drain;
		pending_corners.push_back(c);
	endtask

	function automatic logic [KEY_W-1:0] extreme_pair();
		logic [POS_W-1:0] pos;
		logic [TEX_W-1:0] tex;
		case ($urandom_range(0, 2))
			0:       pos = '0;
			1:       pos = '1;
			default: pos = POS_W'($urandom);
		endcase
		case ($urandom_range(0, 2))
			0:       tex = '0;
			1:       tex = '1;
			default: tex = TEX_W'($urandom);
		endcase
		return {pos, tex};
	endfunction

	// Typical mesh: a small pool of pairs (some sharing one half) reused across corners,
	// with fresh pairs, extremes and a stray mesh restart mixed in
	task automatic add_small_mesh(input bit drain);
		logic [KEY_W-1:0] pool[$];
		logic [KEY_W-1:0] key;
		int               pool_len;
		int               corners;
		int               roll;
		pool_len = $urandom_range(1, 40);
		for (int k = 0; k < pool_len; k++) begin
			key = $urandom;
			if (k > 0 && $urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 1) == 0)
					key[KEY_W-1:TEX_W] = pool[$][KEY_W-1:TEX_W];
				else
					key[TEX_W-1:0] = pool[$][TEX_W-1:0];
			end
			pool.push_back(key);
		end
		corners = $urandom_range(3, 2 * pool_len + 8);
		for (int c = 0; c < corners; c++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				key = pool[$urandom_range(0, pool_len - 1)];
			else if (roll < 95)
				key = $urandom;
			else
				key = extreme_pair();
			add_corner(c == 0 || $urandom_range(0, 99) < 3, key, drain && c == 0);
		end
	endtask

	// Mesh with more distinct pairs than the table holds, so it fills and overflows
	task automatic add_full_mesh();
		logic [KEY_W-1:0] used[$];
		logic [KEY_W-1:0] key;
		for (int c = 0; c < FULL_MESH_LEN; c++) begin
			if (c > 0 && $urandom_range(0, 99) < 8)
				key = used[$urandom_range(0, used.size() - 1)];
			else
				key = $urandom;
			used.push_back(key);
			add_corner(c == 0, key, c == 0);
		end
	endtask

	// Request capture, prediction and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_took <= in_valid && !in_stall;
			out_took <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				expected_vertices.push_back(
					predict_corner(first_of_mesh, position_index, texcoord_index));
				quiet_cycles = 0;
			end else if (out_valid && !out_stall) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("mesh_corner_vertex_dedup: mismatch");
				$finish;
			end
		end
	end

	// Driver: one request from the pending queue, random gap after each accepted one
	always @(negedge clk) begin
		corner_item_t item;
		bit           loaded;
		loaded = 1'b0;
		if (arst_n) begin
			if (in_took) begin
				drv_busy = 1'b0;
				in_gap = draw_wait(in_mode);
			end
			if (!drv_busy) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_corners.size() > 0 &&
						!(pending_corners[0].drain && expected_vertices.size() > 0)) begin
					item = pending_corners.pop_front();
					drv_busy = 1'b1;
					loaded = 1'b1;
				end
			end
			if (loaded) begin
				first_of_mesh <= item.first;
				position_index <= item.pos;
				texcoord_index <= item.tex;
			end else if (!drv_busy) begin
				// junk on idle cycles must be ignored
				first_of_mesh <= 1'($urandom_range(0, 1));
				position_index <= POS_W'($urandom);
				texcoord_index <= TEX_W'($urandom);
			end
			in_valid <= drv_busy;
		end
	end

	// Receiver stall: random per result, plus two long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				out_wait = draw_wait(out_mode);
				if (results_seen == 60 || results_seen == 700)
					holdoff_left = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else if (out_wait > 0 && out_valid) begin
				out_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		vertex_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_vertices.size() == 0) begin
				report_mismatch("result with no request pending, vertex_number",
					int'(vertex_number), 0);
			end else begin
				want = expected_vertices.pop_front();
				if (vertex_number !== want.number)
					report_mismatch("vertex_number", int'(vertex_number),
						int'(want.number));
				if (is_new_vertex !== want.is_new)
					report_mismatch("is_new_vertex", int'(is_new_vertex),
						int'(want.is_new));
				if (table_overflow !== want.overflow)
					report_mismatch("table_overflow", int'(table_overflow),
						int'(want.overflow));
				if (distinct_count !== want.count)
					report_mismatch("distinct_count", int'(distinct_count),
						int'(want.count));
			end
		end
	end

	initial begin
		// Directed: extremes, hits, restart on a fresh table and on a used one
		add_corner(1'b1, {16'h0000, 16'h0000}, 1'b0);
		add_corner(1'b0, {16'hFFFF, 16'hFFFF}, 1'b0);
		add_corner(1'b0, {16'h0000, 16'hFFFF}, 1'b0);
		add_corner(1'b0, {16'hFFFF, 16'h0000}, 1'b0);
		add_corner(1'b0, {16'h0000, 16'h0000}, 1'b0);
		add_corner(1'b0, {16'hFFFF, 16'hFFFF}, 1'b0);
		add_corner(1'b0, {16'h8000, 16'h0001}, 1'b0);
		add_corner(1'b0, {16'h0001, 16'h8000}, 1'b0);
		add_corner(1'b0, {16'hFFFF, 16'h0000}, 1'b0);
		add_corner(1'b0, {16'hAAAA, 16'h5555}, 1'b0);
		add_corner(1'b0, {16'h5555, 16'hAAAA}, 1'b0);
		add_corner(1'b1, {16'hFFFF, 16'hFFFF}, 1'b0);
		add_corner(1'b0, {16'h0000, 16'h0000}, 1'b0);
		add_corner(1'b0, {16'h0000, 16'h0000}, 1'b0);
		add_corner(1'b1, {16'h0000, 16'h0000}, 1'b0);
		add_corner(1'b1, {16'h0000, 16'h0000}, 1'b0);

		// Random meshes; the first waits for the directed results to drain
		add_small_mesh(1'b1);
		while (pending_corners.size() < 150)
			add_small_mesh(1'b0);
		add_full_mesh();
		while (pending_corners.size() < 560)
			add_small_mesh($urandom_range(0, 3) == 0);
		add_full_mesh();
		while (pending_corners.size() < TOTAL_ITEMS)
			add_small_mesh(1'b0);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_corners.size() > 0 || drv_busy || expected_vertices.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_vertices.size() > 0)
			report_mismatch("results still owed", expected_vertices.size(), 0);
		if (mismatch_count == 0)
			$display("mesh_corner_vertex_dedup: match");
		else
			$display("mesh_corner_vertex_dedup: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mcvd_pkg.sv
rtl/mcvd_ram.sv
rtl/mcvd_front.sv
rtl/mcvd_back.sv
rtl/mesh_corner_vertex_dedup.sv
bench/mesh_corner_vertex_dedup_tb.sv
